[src/ir_pulse_distance_frame_decoder_assert.svh]
`ifndef IR_PULSE_DISTANCE_FRAME_DECODER_ASSERT_SVH
`define IR_PULSE_DISTANCE_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IRPD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define IRPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/irpd_pkg.sv]
`timescale 1ns / 1ps

package irpd_pkg;

  localparam int TimerWidth = 16;
  localparam int CfgWidth   = 16;
  localparam int CfgIdxW    = 2;
  localparam int ByteW      = 8;

  typedef logic [TimerWidth-1:0] timer_t;
  typedef logic [ByteW-1:0]      byte_t;
  typedef logic [CfgIdxW-1:0]    cfg_idx_t;
  typedef logic [CfgWidth-1:0]   cfg_data_t;

  localparam cfg_idx_t RegBitOneThreshold = 2'd0;
  localparam cfg_idx_t RegLeaderMin       = 2'd1;
  localparam cfg_idx_t RegLeaderMax       = 2'd2;
  localparam cfg_idx_t RegCheckEnable     = 2'd3;

  localparam timer_t ResetBitOneThreshold = timer_t'(49);
  localparam timer_t ResetLeaderMin       = timer_t'(131);
  localparam timer_t ResetLeaderMax       = timer_t'(262);

  typedef struct packed {
    timer_t bit_one_threshold;
    timer_t leader_min;
    timer_t leader_max;
    logic   check_enable;
  } cfg_t;

  typedef struct packed {
    logic  emit;
    byte_t byte0;
    byte_t byte1;
    byte_t byte2;
    byte_t byte3;
  } result_t;

endpackage

[src/irpd_capture_if.sv]
`timescale 1ns / 1ps

interface irpd_capture_if;
  import irpd_pkg::*;

  logic   valid;
  logic   ready;
  timer_t capture_time;

  modport source (output valid, output capture_time, input ready);
  modport sink (input valid, input capture_time, output ready);
endinterface

[src/irpd_frame_if.sv]
`timescale 1ns / 1ps

interface irpd_frame_if;
  import irpd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t byte0;
  byte_t byte1;
  byte_t byte2;
  byte_t byte3;

  modport source (output valid, output byte0, output byte1, output byte2, output byte3,
                  input ready);
  modport sink (input valid, input byte0, input byte1, input byte2, input byte3,
                output ready);
endinterface

[src/irpd_decode.sv]
`timescale 1ns / 1ps

module irpd_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  irpd_pkg::timer_t capture_time,
  input  irpd_pkg::cfg_t   cfg,
  output irpd_pkg::result_t result
);
  import irpd_pkg::*;

  localparam logic [2:0] LastBit  = 3'd7;
  localparam logic [1:0] LastByte = 2'd3;

  timer_t     previous_capture;
  logic       reading;
  byte_t      shift_byte;
  logic [2:0] bit_count;
  logic [1:0] byte_count;
  byte_t      frame_bytes [3];

  timer_t interval;
  logic   bit_value;
  byte_t  shift_byte_next;
  logic   byte_done;
  logic   frame_done;
  logic   leader;
  logic   sums_match;
  logic   reading_next;

  always_comb begin
    interval        = capture_time - previous_capture;
    bit_value       = interval > cfg.bit_one_threshold;
    shift_byte_next = {shift_byte[ByteW-2:0], bit_value};
    byte_done       = reading && (bit_count == LastBit);
    frame_done      = byte_done && (byte_count == LastByte);
    leader          = (interval > cfg.leader_min) && (interval < cfg.leader_max);
    sums_match      = ({1'b0, frame_bytes[0]} + {1'b0, frame_bytes[1]}) ==
                      ({1'b0, frame_bytes[2]} + {1'b0, shift_byte_next});
    // a leader wins over the end of a frame
    reading_next    = leader || (reading && !frame_done);

    result.emit  = frame_done && (!cfg.check_enable || sums_match);
    result.byte0 = frame_bytes[0];
    result.byte1 = frame_bytes[1];
    result.byte2 = frame_bytes[2];
    result.byte3 = shift_byte_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_capture <= '0;
      reading          <= 1'b0;
      shift_byte       <= '0;
      bit_count        <= '0;
      byte_count       <= '0;
    end else if (step) begin
      previous_capture <= capture_time;
      reading          <= reading_next;
      if (reading) begin
        shift_byte <= shift_byte_next;
        bit_count  <= bit_count + 3'd1;
      end
      if (byte_done) begin
        byte_count <= byte_count + 2'd1;
      end
    end
  end

  // frame byte store; the last byte goes straight out of the shifter
  always_ff @(posedge clk) begin
    if (step && byte_done && (byte_count != LastByte)) begin
      frame_bytes[byte_count] <= shift_byte_next;
    end
  end

endmodule

[src/ir_pulse_distance_frame_decoder.sv]
`timescale 1ns / 1ps
`include "ir_pulse_distance_frame_decoder_assert.svh"

// Channel   Role    Payload                        Moves one request per
// --------  ------  -----------------------------  ---------------------------
// capture   sink    capture_time (16 bit)          rising edge of the receiver
// frame     source  byte0, byte1, byte2, byte3     decoded frame that passes
// cfg_*     write   cfg_index (2 bit), cfg_data    register write
//
// One capture request is taken every cycle while the capture stage is not held.
// A request waits in the capture stage, where one subtract, the threshold
// compares and the shift run, then lands in the frame register.
// Reset (rst, synchronous) clears the decoder state and restores the
// register defaults; no clearing pass is needed.
// The capture stage holds only when its edge completes a frame and the frame
// register is still waiting for the sink; other edges pass a stalled output.
module ir_pulse_distance_frame_decoder (
  input  logic                 clk,
  input  logic                 rst,
  irpd_capture_if.sink         capture,
  irpd_frame_if.source         frame,
  input  logic                 cfg_write,
  input  irpd_pkg::cfg_idx_t   cfg_index,
  input  irpd_pkg::cfg_data_t  cfg_data
);
  import irpd_pkg::*;

  // Configuration registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_one_threshold <= ResetBitOneThreshold;
      cfg.leader_min        <= ResetLeaderMin;
      cfg.leader_max        <= ResetLeaderMax;
      cfg.check_enable      <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        RegBitOneThreshold: cfg.bit_one_threshold <= timer_t'(cfg_data);
        RegLeaderMin:       cfg.leader_min        <= timer_t'(cfg_data);
        RegLeaderMax:       cfg.leader_max        <= timer_t'(cfg_data);
        RegCheckEnable:     cfg.check_enable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture stage
  logic    stage_valid;
  timer_t  stage_capture;
  logic    advance;
  logic    out_free;
  result_t result;

  // advance the stage unless it would emit into a full frame register
  assign out_free      = !frame.valid || frame.ready;
  assign advance       = stage_valid && (out_free || !result.emit);
  assign capture.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (capture.ready) begin
      stage_valid <= capture.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (capture.valid && capture.ready) begin
      stage_capture <= capture.capture_time;
    end
  end

  irpd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .capture_time (stage_capture),
    .cfg          (cfg),
    .result       (result)
  );

  // Frame register: load on an emitting step, drop once the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (advance && result.emit) begin
      frame.valid <= 1'b1;
    end else if (frame.ready) begin
      frame.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      frame.byte0 <= result.byte0;
      frame.byte1 <= result.byte1;
      frame.byte2 <= result.byte2;
      frame.byte3 <= result.byte3;
    end
  end

  // A new frame only comes from a decoder step
  `IRPD_ASSERT_SAME(a_frame_from_step, clk, rst, $rose(frame.valid), $past(advance && result.emit), "frame appeared without an emitting step")

  // With checking on, every frame shown passes the sum check
  `IRPD_ASSERT_SAME(a_frame_checked, clk, rst, frame.valid && cfg.check_enable, ({1'b0, frame.byte0} + {1'b0, frame.byte1}) == ({1'b0, frame.byte2} + {1'b0, frame.byte3}), "frame failed the sum check")

  // A held capture stage keeps its edge
  `IRPD_ASSERT_NEXT(a_stage_hold, clk, rst, stage_valid && !advance, stage_valid && $stable(stage_capture), "capture stage lost its edge")

endmodule

[test/irpd_frame_checker.sv]
`timescale 1ns / 1ps

module irpd_frame_checker (
  input  logic                clk,
  input  logic                rst,
  irpd_capture_if             capture,
  irpd_frame_if               frame,
  input  logic                cfg_write,
  input  irpd_pkg::cfg_idx_t  cfg_index,
  input  irpd_pkg::cfg_data_t cfg_data,
  output int                  mismatches,
  output int                  frames_owed
);
  import irpd_pkg::*;

  // byte0 sits in slot 0
  typedef logic [3:0][ByteW-1:0] frame_t;

  cfg_t     regs;
  timer_t   last_stamp;
  logic     reading;
  byte_t    shift_reg;
  logic [2:0] bit_pos;
  logic [1:0] byte_pos;
  frame_t   frame_store;
  frame_t   frames_due [$];

  // Advance the decoder by one rising-edge capture.
  task automatic decode_capture(input timer_t stamp);
    timer_t     span;
    logic       one;
    logic [8:0] lo_sum;
    logic [8:0] hi_sum;
    span = stamp - last_stamp;
    if (reading) begin
      one       = span > regs.bit_one_threshold;
      shift_reg = {shift_reg[ByteW-2:0], one};
      bit_pos   = bit_pos + 3'd1;
      if (bit_pos == 3'd0) begin
        frame_store[byte_pos] = shift_reg;
        byte_pos = byte_pos + 2'd1;
        if (byte_pos == 2'd0) begin
          reading = 1'b0;
          lo_sum  = 9'(frame_store[0]) + 9'(frame_store[1]);
          hi_sum  = 9'(frame_store[2]) + 9'(frame_store[3]);
          if (!regs.check_enable || lo_sum == hi_sum) frames_due.push_back(frame_store);
        end
      end
    end
    if (span > regs.leader_min && span < regs.leader_max) reading = 1'b1;
    last_stamp = stamp;
  endtask

  always @(posedge clk) begin
    frame_t got;
    frame_t want;
    if (rst) begin
      regs.bit_one_threshold = ResetBitOneThreshold;
      regs.leader_min        = ResetLeaderMin;
      regs.leader_max        = ResetLeaderMax;
      regs.check_enable      = 1'b1;
      last_stamp  = '0;
      reading     = 1'b0;
      shift_reg   = '0;
      bit_pos     = '0;
      byte_pos    = '0;
      frame_store = '0;
      frames_due.delete();
      mismatches  = 0;
    end else begin
      if (frame.valid && frame.ready) begin
        got = {frame.byte3, frame.byte2, frame.byte1, frame.byte0};
        if (frames_due.size() == 0) begin
          $display("%0t: frame with none pending: expected nothing, got %h %h %h %h",
                   $time, got[0], got[1], got[2], got[3]);
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got[i] !== want[i]) begin
              $display("%0t: byte%0d mismatch: expected %h, got %h",
                       $time, i, want[i], got[i]);
              mismatches++;
            end
          end
        end
      end
      if (capture.valid && capture.ready) decode_capture(capture.capture_time);
      if (cfg_write) begin
        case (cfg_index)
          RegBitOneThreshold: regs.bit_one_threshold = cfg_data;
          RegLeaderMin:       regs.leader_min        = cfg_data;
          RegLeaderMax:       regs.leader_max        = cfg_data;
          RegCheckEnable:     regs.check_enable      = cfg_data[0];
          default: ;
        endcase
      end
    end
    frames_owed = frames_due.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
  import irpd_pkg::*;

  // Abort when this many cycles pass with no request moving on either channel.
  localparam int WatchdogLimit = 2000;

  logic      clk;
  logic      rst;
  logic      cfg_write;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  irpd_capture_if capture ();
  irpd_frame_if   frame ();

  int mismatches;
  int frames_owed;
  int items_sent;
  int frames_taken;
  int idle_cycles;

  // Shadow of the register contents, used to shape the stimulus only.
  timer_t thr_set;
  timer_t lmin_set;
  timer_t lmax_set;

  // Free-running timer as the receiver would see it; wraps naturally at 16 bits.
  timer_t clock_now;

  // Set to drop idling on one side for a whole phase.
  logic sender_quiet;
  logic sink_quiet;

  ir_pulse_distance_frame_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .capture   (capture),
    .frame     (frame),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  irpd_frame_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .capture     (capture),
    .frame       (frame),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .frames_owed (frames_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: count cycles in which no request moves, and give up past the limit.
  // Also count delivered frames so the random part knows when enough have come.
  always @(posedge clk) begin
    if (frame.valid && frame.ready) frames_taken <= frames_taken + 1;
    if (rst || (capture.valid && capture.ready) || (frame.valid && frame.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Frame sink: stall a random number of cycles before each frame, then hold
  // ready high until one request is taken. Never lower and raise ready in one step.
  initial begin
    int stall;
    frame.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = sink_quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        frame.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      frame.ready <= 1'b1;
      do @(posedge clk); while (!frame.valid);
      @(negedge clk);
    end
  end

  // Write all four registers on consecutive cycles. Call at a falling edge
  // while the block is idle. Junk in the upper bits of the check_enable write
  // must be ignored by the block.
  task automatic program_registers(input timer_t thr, input timer_t lmin,
                                   input timer_t lmax, input logic chk);
    cfg_data_t junk;
    junk    = cfg_data_t'($urandom);
    junk[0] = chk;
    cfg_write <= 1'b1;
    cfg_index <= RegBitOneThreshold;
    cfg_data  <= thr;
    @(negedge clk);
    cfg_index <= RegLeaderMin;
    cfg_data  <= lmin;
    @(negedge clk);
    cfg_index <= RegLeaderMax;
    cfg_data  <= lmax;
    @(negedge clk);
    cfg_index <= RegCheckEnable;
    cfg_data  <= junk;
    @(negedge clk);
    cfg_write <= 1'b0;
    thr_set  = thr;
    lmin_set = lmin;
    lmax_set = lmax;
  endtask

  // Offer one capture request after a random gap and hold it until taken.
  // Entered and left at a falling edge; valid stays high when the next gap is zero.
  task automatic send_capture(input timer_t stamp);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      capture.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    capture.valid        <= 1'b1;
    capture.capture_time <= stamp;
    do @(posedge clk); while (!capture.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Advance the timer by an interval and capture the new value.
  task automatic send_interval(input timer_t span);
    clock_now = clock_now + span;
    send_capture(clock_now);
  endtask

  // Pick an interval that decodes as the wanted bit (no one can be made with an
  // all-ones threshold). Lean on the threshold itself now and then, and sometimes reach far above it.
  function automatic timer_t bit_interval(input logic one);
    int room;
    int extra;
    if (one && thr_set != '1) begin
      room = 65535 - int'(thr_set) - 1;
      if ($urandom_range(0, 7) == 0) extra = 0;
      else if ($urandom_range(0, 7) == 0) extra = $urandom_range(0, room);
      else extra = $urandom_range(0, (room < 200) ? room : 200);
      return timer_t'(int'(thr_set) + 1 + extra);
    end
    if ($urandom_range(0, 7) == 0) return thr_set;
    return timer_t'($urandom_range(0, int'(thr_set)));
  endfunction

  // Pick a leader interval, one tick inside either bound now and then; with an empty
  // leader window anything goes.
  function automatic timer_t leader_interval();
    if (int'(lmax_set) - int'(lmin_set) < 2) return timer_t'($urandom);
    case ($urandom_range(0, 5))
      0:       return lmin_set + 16'd1;
      1:       return lmax_set - 16'd1;
      default: return timer_t'($urandom_range(int'(lmin_set) + 1, int'(lmax_set) - 1));
    endcase
  endfunction

  // Four bytes, byte0 in the top byte. Mostly with matching sums so that
  // the check passes; the rest fully random.
  function automatic logic [31:0] frame_word();
    int b0;
    int b1;
    int b2;
    int sum;
    b0 = $urandom_range(0, 255);
    b1 = $urandom_range(0, 255);
    if ($urandom_range(0, 3) == 0) return $urandom;
    sum = b0 + b1;
    b2  = $urandom_range((sum > 255) ? sum - 255 : 0, (sum > 255) ? 255 : sum);
    return {byte_t'(b0), byte_t'(b1), byte_t'(b2), byte_t'(sum - b2)};
  endfunction

  // Shift out the leading bits of a frame word, MSB first.
  task automatic send_bits(input logic [31:0] word, input int nbits);
    for (int i = 31; i >= 32 - nbits; i--) send_interval(bit_interval(word[i]));
  endtask

  // Pause the sender until every pending frame has come, then let the
  // capture stage empty before any register is touched.
  task automatic drain_and_hold();
    capture.valid <= 1'b0;
    while (frames_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [31:0] word;
    timer_t      span;
    int          ones_seen;
    int          pick;
    int          quota;
    int          first_item;
    int          phase;

    rst                  = 1'b1;
    capture.valid        = 1'b0;
    capture.capture_time = '0;
    cfg_write            = 1'b0;
    cfg_index            = RegBitOneThreshold;
    cfg_data             = '0;
    items_sent           = 0;
    clock_now            = '0;
    sender_quiet         = 1'b0;
    sink_quiet           = 1'b0;
    thr_set              = ResetBitOneThreshold;
    lmin_set             = ResetLeaderMin;
    lmax_set             = ResetLeaderMax;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed part, at the reset defaults. Leader bounds first: both bounds
    // themselves are not leaders, one tick inside the upper bound is.
    send_interval(ResetLeaderMin);
    send_interval(ResetLeaderMax);
    send_interval(ResetLeaderMax - 16'd1);
    // Then one frame whose sums match, with an all-zero and an all-one byte.
    // Zeros use an empty interval and the threshold itself; ones use one
    // tick above the threshold, the widest interval (wraps the timer) and a
    // leader mid-frame, which must decode as a bit. The last bit is a leader
    // too, so reading restarts right after the frame.
    word      = 32'h00FF_807F;
    ones_seen = 0;
    for (int i = 31; i >= 0; i--) begin
      if (i == 0) begin
        span = ResetLeaderMin + 16'd1;
      end else if (!word[i]) begin
        span = i[0] ? 16'd0 : ResetBitOneThreshold;
      end else begin
        case (ones_seen % 3)
          0:       span = ResetBitOneThreshold + 16'd1;
          1:       span = 16'hFFFF;
          default: span = 16'd200;
        endcase
        ones_seen++;
      end
      send_interval(span);
    end
    drain_and_hold();

    // Random part in phases, each with its own register setting. Phase 0
    // keeps the defaults; phases 1 to 3 take the extremes, including an empty
    // leader window; phase 4 restores them; the rest draw settings at random.
    phase = 0;
    while (phase < 30 && (items_sent < 700 || frames_taken < 40)) begin
      case (phase)
        0: ;
        1: program_registers(16'd0, 16'd0, 16'hFFFF, 1'b0);
        2: program_registers(16'hFFFF, 16'hFFFE, 16'hFFFF, 1'b1);
        3: program_registers(16'hFFFE, 16'hFFFD, 16'hFFFF, 1'b0);
        4: program_registers(ResetBitOneThreshold, ResetLeaderMin, ResetLeaderMax, 1'b1);
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            program_registers(timer_t'($urandom), timer_t'($urandom),
                              timer_t'($urandom), 1'($urandom));
          end else begin
            span = timer_t'($urandom_range(0, 3000));
            word = 32'(span) + $urandom_range(0, 3000);
            program_registers(span, timer_t'(word),
                              timer_t'(word + 2 + $urandom_range(0, 5000)),
                              1'($urandom_range(0, 1)));
          end
        end
      endcase
      sender_quiet = ($urandom_range(0, 3) == 0);
      sink_quiet   = ($urandom_range(0, 3) == 0);
      quota        = (phase == 2) ? 40 : 150;
      first_item   = items_sent;
      while (items_sent - first_item < quota) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          // Well-formed frame: leader, then 32 bits.
          send_interval(leader_interval());
          send_bits(frame_word(), 32);
        end else if (pick < 9) begin
          // Broken frame: cut short; the counts carry over into the next one.
          send_interval(leader_interval());
          send_bits(frame_word(), $urandom_range(1, 31));
        end else begin
          // Noise: arbitrary intervals.
          repeat ($urandom_range(1, 4)) send_interval(timer_t'($urandom));
        end
      end
      drain_and_hold();
      phase++;
    end

    // Let any stray frame surface before the verdict.
    repeat (10) @(posedge clk);
    if (mismatches == 0 && frames_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/irpd_pkg.sv
src/irpd_capture_if.sv
src/irpd_frame_if.sv
src/irpd_decode.sv
src/ir_pulse_distance_frame_decoder.sv
test/irpd_frame_checker.sv
test/tb.sv
